>>> rtl/rgba_pkg.sv
// shared constants, widths and word types for the rgba over-blend pipeline
// no dependencies; used by the interfaces, rgba_div and the top level
package rgba_pkg;

  localparam int CB   = 8;                 // channel bits
  localparam int CMAX = (1 << CB) - 1;     // full intensity / opaque
  localparam int AW   = 2 * CB;            // alpha sum width, asum <= CMAX^2
  localparam int NW   = 3 * CB + 1;        // blend numerator width, < 2*CMAX^3

  // floor(asum / CMAX) by reciprocal multiply, exact for asum < 2^(2*CB)
  localparam int RSH = 3 * CB;
  localparam longint unsigned RECIP = ((64'd1 << RSH) + CMAX - 1) / CMAX;
  localparam int RW  = 2 * CB + 1;
  localparam int PW  = AW + RW;

  // divider: quotient bits resolved per stage
  localparam int DSTEPS  = 2;
  localparam int DSTAGES = (CB + DSTEPS - 1) / DSTEPS;

  typedef logic [CB-1:0] chan_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t alpha;
    logic  wr;
  } pix_t;

  typedef struct packed {
    logic [2:0][NW-1:0] num;
    logic [AW-1:0]      asum;
    chan_t              alpha;
    logic               bypass;
    pix_t               pass_pix;
  } div_req_t;

endpackage

>>> rtl/rgba_if.sv
// valid/ready channel interfaces for source/destination pixel pairs and results
// depends on rgba_pkg for the channel type
interface rgba_in_if;
  import rgba_pkg::*;

  logic  valid;
  logic  ready;
  chan_t src_red;
  chan_t src_green;
  chan_t src_blue;
  chan_t src_opacity;
  chan_t dst_red;
  chan_t dst_green;
  chan_t dst_blue;
  chan_t dst_opacity;

  modport source (
    output valid, src_red, src_green, src_blue, src_opacity,
    output dst_red, dst_green, dst_blue, dst_opacity,
    input  ready
  );
  modport sink (
    input  valid, src_red, src_green, src_blue, src_opacity,
    input  dst_red, dst_green, dst_blue, dst_opacity,
    output ready
  );
endinterface

interface rgba_out_if;
  import rgba_pkg::*;

  logic  valid;
  logic  ready;
  chan_t out_red;
  chan_t out_green;
  chan_t out_blue;
  chan_t out_opacity;
  logic  write_back;

  modport source (
    output valid, out_red, out_green, out_blue, out_opacity, write_back,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, out_opacity, write_back,
    output ready
  );
endinterface

>>> rtl/rgba_div.sv
// pipelined restoring divider, three colour quotients against a shared alpha sum
// depends on rgba_pkg; last stage register is the result word register
module rgba_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  output logic              req_ready,
  input  rgba_pkg::div_req_t req,
  output logic              res_valid,
  input  logic              res_ready,
  output rgba_pkg::pix_t    res
);
  import rgba_pkg::*;

  logic [DSTAGES-1:0]     dv_r;
  logic [2:0][AW-1:0]     rem_r   [DSTAGES];
  logic [2:0][CB-1:0]     low_r   [DSTAGES];
  logic [2:0][CB-1:0]     q_r     [DSTAGES];
  logic [AW-1:0]          asum_r  [DSTAGES];
  chan_t                  alpha_r [DSTAGES];
  logic [DSTAGES-1:0]     byp_r;
  pix_t                   pass_r  [DSTAGES];

  logic [2:0][AW-1:0]     rem_nxt [DSTAGES];
  logic [2:0][CB-1:0]     low_nxt [DSTAGES];
  logic [2:0][CB-1:0]     q_nxt   [DSTAGES];
  logic [AW-1:0]          asum_in [DSTAGES];
  chan_t                  alpha_in[DSTAGES];
  logic [DSTAGES-1:0]     byp_in;
  logic [DSTAGES-1:0]     v_in;
  pix_t                   pass_in [DSTAGES];

  logic [DSTAGES:0]       en;

  // a stage moves when empty or when the one after it moves
  always_comb begin
    en[DSTAGES] = res_ready;
    for (int s = DSTAGES - 1; s >= 0; s--) begin
      en[s] = !dv_r[s] || en[s+1];
    end
  end

  assign req_ready = en[0];

  always_comb begin
    logic [AW:0] t;
    t = '0;
    for (int s = 0; s < DSTAGES; s++) begin
      if (s == 0) begin
        v_in[s]     = req_valid;
        asum_in[s]  = req.asum;
        alpha_in[s] = req.alpha;
        byp_in[s]   = req.bypass;
        pass_in[s]  = req.pass_pix;
        for (int c = 0; c < 3; c++) begin
          // numerator / 2^CB is below asum, so the top bit is zero
          rem_nxt[s][c] = req.num[c][CB +: AW];
          low_nxt[s][c] = req.num[c][CB-1:0];
          q_nxt[s][c]   = '0;
        end
      end else begin
        v_in[s]     = dv_r[s-1];
        asum_in[s]  = asum_r[s-1];
        alpha_in[s] = alpha_r[s-1];
        byp_in[s]   = byp_r[s-1];
        pass_in[s]  = pass_r[s-1];
        rem_nxt[s]  = rem_r[s-1];
        low_nxt[s]  = low_r[s-1];
        q_nxt[s]    = q_r[s-1];
      end
      for (int c = 0; c < 3; c++) begin
        for (int j = 0; j < DSTEPS; j++) begin
          if (s * DSTEPS + j < CB) begin
            t = {rem_nxt[s][c], low_nxt[s][c][CB-1]};
            low_nxt[s][c] = {low_nxt[s][c][CB-2:0], 1'b0};
            if (t >= {1'b0, asum_in[s]}) begin
              rem_nxt[s][c] = AW'(t - {1'b0, asum_in[s]});
              q_nxt[s][c]   = {q_nxt[s][c][CB-2:0], 1'b1};
            end else begin
              rem_nxt[s][c] = t[AW-1:0];
              q_nxt[s][c]   = {q_nxt[s][c][CB-2:0], 1'b0};
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DSTAGES; s++) begin
      if (!rst_n) begin
        dv_r[s] <= 1'b0;
      end else if (en[s]) begin
        dv_r[s] <= v_in[s];
      end
      if (en[s]) begin
        rem_r[s]   <= rem_nxt[s];
        low_r[s]   <= low_nxt[s];
        q_r[s]     <= q_nxt[s];
        asum_r[s]  <= asum_in[s];
        alpha_r[s] <= alpha_in[s];
        byp_r[s]   <= byp_in[s];
        pass_r[s]  <= pass_in[s];
      end
    end
  end

  assign res_valid = dv_r[DSTAGES-1];

  always_comb begin
    if (byp_r[DSTAGES-1]) begin
      res = pass_r[DSTAGES-1];
    end else begin
      res.red   = q_r[DSTAGES-1][0];
      res.green = q_r[DSTAGES-1][1];
      res.blue  = q_r[DSTAGES-1][2];
      res.alpha = alpha_r[DSTAGES-1];
      res.wr    = 1'b1;
    end
  end

`ifndef ASSERT_OFF
  // quotient must fit in a channel: numerator below asum * 2^CB
  a_quot_fits: assert property (@(posedge clk) disable iff (!rst_n)
    req_valid && req_ready && !req.bypass |->
      (req.num[0][NW-1:CB] < {1'b0, req.asum}) &&
      (req.num[1][NW-1:CB] < {1'b0, req.asum}) &&
      (req.num[2][NW-1:CB] < {1'b0, req.asum}))
    else $error("blend numerator too large for channel quotient");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r[DSTAGES-1] && !byp_r[DSTAGES-1] |->
      (rem_r[DSTAGES-1][0] < asum_r[DSTAGES-1]) &&
      (rem_r[DSTAGES-1][1] < asum_r[DSTAGES-1]) &&
      (rem_r[DSTAGES-1][2] < asum_r[DSTAGES-1]))
    else $error("final remainder not below divisor");

  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    res_ready |-> req_ready)
    else $error("divider stalls while its output drains");
`endif

endmodule

>>> rtl/rgba_over_alpha_blend.sv
// 8 stages (4 blend + 4 divider); the last divider stage register holds the result word
// throughput: one pixel pair per clock when not stalled; two quotient bits per divider stage
// a full pipe passes a stall at the output back to the input in the same cycle; empty
// stages keep filling while a result word waits at the output
// reset (rst_n low, synchronous) clears the stage valid bits only; no result words after reset
// top level of the non-premultiplied over compositor; uses rgba_pkg, rgba_if and rgba_div
module rgba_over_alpha_blend (
  input  logic         clk,
  input  logic         rst_n,
  rgba_in_if.sink      in_ch,
  rgba_out_if.source   out_ch
);
  import rgba_pkg::*;

  // ---------------------------------------------------------------------------
  // stage 1: input register, special-case detection
  // ---------------------------------------------------------------------------
  logic              v1_r;
  chan_t             sa1_r, da1_r;
  logic [2:0][CB-1:0] sc1_r, dc1_r;
  logic              byp1_r;
  pix_t              pass1_r;
  logic              byp1_nxt;
  pix_t              pass1_nxt;

  // ---------------------------------------------------------------------------
  // stage 2: 8x8 products
  // ---------------------------------------------------------------------------
  logic              v2_r;
  logic [2:0][AW-1:0] ps2_r, pd2_r;
  chan_t             sa2_r, ma2_r;
  logic [AW-1:0]     dam2_r;
  logic              byp2_r;
  pix_t              pass2_r;
  logic [2:0][AW-1:0] ps2_nxt, pd2_nxt;
  chan_t             ma2_nxt;
  logic [AW-1:0]     dam2_nxt;

  // ---------------------------------------------------------------------------
  // stage 3: scaled numerator terms, alpha sum
  // ---------------------------------------------------------------------------
  logic              v3_r;
  logic [2:0][3*CB-1:0] ns3_r, nd3_r;
  logic [AW-1:0]     asum3_r;
  logic              byp3_r;
  pix_t              pass3_r;
  logic [2:0][3*CB-1:0] ns3_nxt, nd3_nxt;
  logic [AW-1:0]     asum3_nxt;

  // ---------------------------------------------------------------------------
  // stage 4: numerators, alpha reciprocal product
  // ---------------------------------------------------------------------------
  logic              v4_r;
  logic [2:0][NW-1:0] num4_r;
  logic [PW-1:0]     aprod4_r;
  logic [AW-1:0]     asum4_r;
  logic              byp4_r;
  pix_t              pass4_r;
  logic [2:0][NW-1:0] num4_nxt;
  logic [PW-1:0]     aprod4_nxt;

  // divider handshake
  logic              div_ready;
  div_req_t          div_req;
  logic              res_valid;
  pix_t              res;

  // per-stage advance, back-propagated from the divider
  logic en1, en2, en3, en4;

  assign en4 = !v4_r || div_ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  assign in_ch.ready = en1;

  // transparent source passes destination without write, opaque source passes source
  always_comb begin
    byp1_nxt = (in_ch.src_opacity == '0) || (in_ch.src_opacity == chan_t'(CMAX));
    if (in_ch.src_opacity == '0) begin
      pass1_nxt = {in_ch.dst_red, in_ch.dst_green, in_ch.dst_blue, in_ch.dst_opacity, 1'b0};
    end else begin
      pass1_nxt = {in_ch.src_red, in_ch.src_green, in_ch.src_blue, in_ch.src_opacity, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_ch.valid;
    end
    if (en1) begin
      sa1_r    <= in_ch.src_opacity;
      da1_r    <= in_ch.dst_opacity;
      sc1_r    <= {in_ch.src_blue, in_ch.src_green, in_ch.src_red};
      dc1_r    <= {in_ch.dst_blue, in_ch.dst_green, in_ch.dst_red};
      byp1_r   <= byp1_nxt;
      pass1_r  <= pass1_nxt;
    end
  end

  // sc*sa, dc*da, da*(max - sa)
  always_comb begin
    ma2_nxt = chan_t'(CMAX) - sa1_r;
    for (int c = 0; c < 3; c++) begin
      ps2_nxt[c] = {CB'(0), sc1_r[c]} * {CB'(0), sa1_r};
      pd2_nxt[c] = {CB'(0), dc1_r[c]} * {CB'(0), da1_r};
    end
    dam2_nxt = {CB'(0), da1_r} * {CB'(0), ma2_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
    if (en2) begin
      ps2_r   <= ps2_nxt;
      pd2_r   <= pd2_nxt;
      sa2_r   <= sa1_r;
      ma2_r   <= ma2_nxt;
      dam2_r  <= dam2_nxt;
      byp2_r  <= byp1_r;
      pass2_r <= pass1_r;
    end
  end

  // times max is a shift and subtract; destination term takes one 16x8 multiply
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ns3_nxt[c] = {ps2_r[c], CB'(0)} - {CB'(0), ps2_r[c]};
      nd3_nxt[c] = {CB'(0), pd2_r[c]} * {AW'(0), ma2_r};
    end
    asum3_nxt = {sa2_r, CB'(0)} - {CB'(0), sa2_r} + dam2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
    if (en3) begin
      ns3_r   <= ns3_nxt;
      nd3_r   <= nd3_nxt;
      asum3_r <= asum3_nxt;
      byp3_r  <= byp2_r;
      pass3_r <= pass2_r;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      num4_nxt[c] = {1'b0, ns3_r[c]} + {1'b0, nd3_r[c]};
    end
    aprod4_nxt = PW'(asum3_r) * PW'(RECIP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en4) begin
      v4_r <= v3_r;
    end
    if (en4) begin
      num4_r   <= num4_nxt;
      aprod4_r <= aprod4_nxt;
      asum4_r  <= asum3_r;
      byp4_r   <= byp3_r;
      pass4_r  <= pass3_r;
    end
  end

  // blended alpha = floor(asum / max) comes straight off the reciprocal product
  always_comb begin
    div_req.num      = num4_r;
    div_req.asum     = asum4_r;
    div_req.alpha    = aprod4_r[RSH +: CB];
    div_req.bypass   = byp4_r;
    div_req.pass_pix = pass4_r;
  end

  rgba_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (v4_r),
    .req_ready (div_ready),
    .req       (div_req),
    .res_valid (res_valid),
    .res_ready (out_ch.ready),
    .res       (res)
  );

  assign out_ch.valid       = res_valid;
  assign out_ch.out_red     = res.red;
  assign out_ch.out_green   = res.green;
  assign out_ch.out_blue    = res.blue;
  assign out_ch.out_opacity = res.alpha;
  assign out_ch.write_back  = res.wr;

`ifndef ASSERT_OFF
  // input side only backs up once the first stage holds a word
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> v1_r)
    else $error("input stalled with empty first stage");

  a_hold_num: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && !en4 |=> $stable(num4_r) && $stable(asum4_r) && v4_r)
    else $error("stalled stage 4 word changed");

  a_transparent: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && (sa1_r == '0) |-> byp1_r && !pass1_r.wr && (pass1_r.alpha == da1_r))
    else $error("transparent source not passed as destination");
`endif

endmodule

>>> tb/sv/tb_top.sv
// self-checking bench for rgba_over_alpha_blend: over-blend predictor, directed and random
// pixel pairs, random backpressure; depends on rgba_pkg, rgba_in_if/rgba_out_if and the rtl
module tb_top;
  import rgba_pkg::*;

  localparam int IDLE_PCT     = 19;     // share of cycles either side sits idle
  localparam int RANDOM_PAIRS = 1600;
  localparam int STEADY_FIRST = 600;    // window of the random run with no idling at all
  localparam int STEADY_LAST  = 900;
  localparam int STALL_LIMIT  = 2000;   // cycles with no word moving on either channel
  localparam int DRAIN_CYCLES = 16;     // pipeline is 8 deep; extra wait after the queue drains

  // one rgba pixel as it sits on the input channel
  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t alpha;
  } rgba_t;

  logic clk;
  logic rst_n;

  rgba_in_if  in_ch ();
  rgba_out_if out_ch ();

  // blended pixels still owed by the block, oldest first
  pix_t blended_q[$];
  int   mismatches;
  int   quiet_cycles;
  bit   no_idle;

  rgba_over_alpha_blend u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic rgba_t rgba(chan_t r, chan_t g, chan_t b, chan_t a);
    rgba_t px;
    px.red   = r;
    px.green = g;
    px.blue  = b;
    px.alpha = a;
    return px;
  endfunction

  // non-premultiplied over: exact integer form, truncating division
  function automatic pix_t over_blend(rgba_t src, rgba_t dst);
    pix_t        res;
    int unsigned sa;
    int unsigned da;
    int unsigned asum;
    int unsigned num;
    chan_t       sc[3];
    chan_t       dc[3];
    chan_t       mix[3];
    sc = '{src.red, src.green, src.blue};
    dc = '{dst.red, dst.green, dst.blue};
    if (src.alpha == '0) begin
      // transparent source: destination unchanged, nothing to write
      res.red   = dst.red;
      res.green = dst.green;
      res.blue  = dst.blue;
      res.alpha = dst.alpha;
      res.wr    = 1'b0;
    end else if (src.alpha == chan_t'(CMAX)) begin
      // opaque source replaces the destination
      res.red   = src.red;
      res.green = src.green;
      res.blue  = src.blue;
      res.alpha = src.alpha;
      res.wr    = 1'b1;
    end else begin
      sa   = src.alpha;
      da   = dst.alpha;
      // alpha sum never below sa*CMAX, so the divisor is nonzero here
      asum = sa * CMAX + da * (CMAX - sa);
      for (int i = 0; i < 3; i++) begin
        num    = sc[i] * sa * CMAX + dc[i] * da * (CMAX - sa);
        mix[i] = chan_t'(num / asum);
      end
      res.red   = mix[0];
      res.green = mix[1];
      res.blue  = mix[2];
      res.alpha = chan_t'(asum / CMAX);
      res.wr    = 1'b1;
    end
    return res;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // random channel value, leaning on the extremes now and then
  function automatic chan_t pick_channel();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8)
      return '0;
    if (r < 16)
      return chan_t'(CMAX);
    return chan_t'($urandom_range(CMAX));
  endfunction

  // alpha mix: plenty of transparent and opaque, the rest partial with edges near the ends
  function automatic chan_t pick_alpha();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15)
      return '0;
    if (r < 30)
      return chan_t'(CMAX);
    if (r < 36)
      return chan_t'(1);
    if (r < 42)
      return chan_t'(CMAX - 1);
    return chan_t'($urandom_range(CMAX - 1, 1));
  endfunction

  // drive one pixel pair word and hold it until the block takes it
  // valid stays high into the next word unless a gap is drawn
  task automatic send_pair(rgba_t src, rgba_t dst);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.src_red     <= src.red;
    in_ch.src_green   <= src.green;
    in_ch.src_blue    <= src.blue;
    in_ch.src_opacity <= src.alpha;
    in_ch.dst_red     <= dst.red;
    in_ch.dst_green   <= dst.green;
    in_ch.dst_blue    <= dst.blue;
    in_ch.dst_opacity <= dst.alpha;
    do
      @(posedge clk);
    while (!in_ch.ready);
  endtask

  // source alpha zero: destination passes through with no write
  task automatic test_transparent_source();
    send_pair(rgba(8'd255, 8'd255, 8'd255, 8'd0), rgba(8'd0, 8'd0, 8'd0, 8'd0));
    send_pair(rgba(8'd0, 8'd0, 8'd0, 8'd0), rgba(8'd255, 8'd255, 8'd255, 8'd255));
    send_pair(rgba(8'd90, 8'd17, 8'd240, 8'd0), rgba(8'd12, 8'd200, 8'd7, 8'd128));
  endtask

  // source alpha full: source replaces destination
  task automatic test_opaque_source();
    send_pair(rgba(8'd255, 8'd255, 8'd255, 8'd255), rgba(8'd0, 8'd0, 8'd0, 8'd0));
    send_pair(rgba(8'd0, 8'd0, 8'd0, 8'd255), rgba(8'd255, 8'd255, 8'd255, 8'd255));
    send_pair(rgba(8'd33, 8'd128, 8'd201, 8'd255), rgba(8'd77, 8'd5, 8'd250, 8'd0));
  endtask

  // partial source alpha, with the destination alpha at its ends and in between
  task automatic test_partial_alpha();
    send_pair(rgba(8'd255, 8'd0, 8'd128, 8'd1), rgba(8'd0, 8'd255, 8'd64, 8'd0));
    send_pair(rgba(8'd255, 8'd0, 8'd128, 8'd1), rgba(8'd0, 8'd255, 8'd64, 8'd255));
    send_pair(rgba(8'd255, 8'd255, 8'd255, 8'd254), rgba(8'd0, 8'd0, 8'd0, 8'd0));
    send_pair(rgba(8'd255, 8'd255, 8'd255, 8'd254), rgba(8'd0, 8'd0, 8'd0, 8'd255));
    send_pair(rgba(8'd0, 8'd0, 8'd0, 8'd254), rgba(8'd255, 8'd255, 8'd255, 8'd255));
    send_pair(rgba(8'd200, 8'd100, 8'd50, 8'd128), rgba(8'd10, 8'd20, 8'd30, 8'd128));
    send_pair(rgba(8'd255, 8'd255, 8'd255, 8'd1), rgba(8'd0, 8'd0, 8'd0, 8'd1));
    send_pair(rgba(8'd0, 8'd255, 8'd0, 8'd127), rgba(8'd255, 8'd0, 8'd255, 8'd255));
    send_pair(rgba(8'd170, 8'd85, 8'd3, 8'd200), rgba(8'd60, 8'd240, 8'd99, 8'd50));
  endtask

  // random stream, with one stretch where neither side idles
  task automatic test_random_pixels();
    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      no_idle = (n >= STEADY_FIRST) && (n < STEADY_LAST);
      send_pair(rgba(pick_channel(), pick_channel(), pick_channel(), pick_alpha()),
                rgba(pick_channel(), pick_channel(), pick_channel(), pick_alpha()));
    end
    no_idle = 1'b0;
  endtask

  // result side backpressure, redrawn every cycle
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // predict on every accepted pixel pair, then check the result word of the same edge
  // prediction goes first so an empty queue never races a push
  always @(posedge clk) begin
    pix_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        blended_q.push_back(over_blend(
          rgba(in_ch.src_red, in_ch.src_green, in_ch.src_blue, in_ch.src_opacity),
          rgba(in_ch.dst_red, in_ch.dst_green, in_ch.dst_blue, in_ch.dst_opacity)));
      if (out_ch.valid && out_ch.ready) begin
        if (blended_q.size() == 0) begin
          $error("result word with no pixel pair waiting");
          mismatches++;
        end else begin
          want = blended_q.pop_front();
          check_field("out_red", want.red, out_ch.out_red);
          check_field("out_green", want.green, out_ch.out_green);
          check_field("out_blue", want.blue, out_ch.out_blue);
          check_field("out_opacity", want.alpha, out_ch.out_opacity);
          check_field("write_back", want.wr, out_ch.write_back);
        end
      end
    end
  end

  // watchdog: too long with no word moving on either channel ends the run
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("rgba_over_alpha_blend: mismatch");
      $finish;
    end
  end

  initial begin
    mismatches   = 0;
    quiet_cycles = 0;
    no_idle      = 1'b0;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.src_red     <= '0;
    in_ch.src_green   <= '0;
    in_ch.src_blue    <= '0;
    in_ch.src_opacity <= '0;
    in_ch.dst_red     <= '0;
    in_ch.dst_green   <= '0;
    in_ch.dst_blue    <= '0;
    in_ch.dst_opacity <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_transparent_source();
    test_opaque_source();
    test_partial_alpha();
    test_random_pixels();

    // drain: wait for every owed word, then a further DRAIN_CYCLES wait for strays
    in_ch.valid <= 1'b0;
    do
      @(posedge clk);
    while (blended_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("rgba_over_alpha_blend: match");
    else
      $display("rgba_over_alpha_blend: mismatch");
    $finish;
  end

endmodule

>>> filelist.f
rtl/rgba_pkg.sv
rtl/rgba_if.sv
rtl/rgba_div.sv
rtl/rgba_over_alpha_blend.sv
tb/sv/tb_top.sv
